[hdl/multiplexed_display_scanner_core_macros.svh]
// Assertion macros for the multiplexed display scanner core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MULTIPLEXED_DISPLAY_SCANNER_CORE_MACROS_SVH
`define MULTIPLEXED_DISPLAY_SCANNER_CORE_MACROS_SVH

// Consequent holds in the same cycle.
`define MDSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Consequent holds in the following cycle.
`define MDSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

[hdl/msc_pkg.sv]
// Shared types, codes and helper functions for the multiplexed display scanner.
// No dependencies.
`default_nettype none

package msc_pkg;

    localparam int BLINK_PERIOD_DEF = 40;
    localparam int NUM_SMALL        = 7;
    localparam int NUM_BAR          = 2;
    localparam int NUM_FRAMES       = 14;
    localparam logic [3:0] LAST_FRAME = 4'd13;
    localparam logic [6:0] NUM_MAX  = 7'd99;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_SET_SMALL = 3'd1;
    localparam logic [2:0] ACT_SET_BIG   = 3'd2;
    localparam logic [2:0] ACT_SET_BAR   = 3'd3;
    localparam logic [2:0] ACT_SET_LED   = 3'd4;
    localparam logic [2:0] ACT_SET_ALL   = 3'd5;

    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_STEADY = 3'd1;
    localparam logic [2:0] MODE_BLINK  = 3'd2;
    localparam logic [2:0] MODE_FAST   = 3'd3;
    localparam logic [2:0] MODE_ERROR  = 3'd4;
    localparam logic [2:0] MODE_LOAD   = 3'd5;
    localparam logic [2:0] MODE_EMPTY  = 3'd6;

    localparam logic [7:0] GLYPH_R     = 8'h50;
    localparam logic [7:0] GLYPH_E     = 8'h79;
    localparam logic [7:0] GLYPH_DASH  = 8'h40;
    localparam logic [7:0] SEL_BIG_LO  = 8'h7F;
    localparam logic [7:0] SEL_BIG_HI  = 8'hBF;
    localparam logic [7:0] SEL_HIGH_BASE = 8'h3F;
    localparam logic [7:0] CATH_KEEP   = 8'hF0;
    localparam logic [7:0] BAR_FULL    = 8'hFF;
    localparam logic [7:0] LED1_BIT    = 8'h20;
    localparam logic [7:0] LED0_BIT    = 8'h10;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] index;
        logic [7:0] value;
        logic [2:0] status;
    } in_t;

    typedef struct packed {
        logic [7:0] led_bar_byte;
        logic [7:0] anode_byte;
        logic [7:0] select_high_byte;
        logic [7:0] select_low_byte;
        logic [7:0] segment_byte;
        logic [3:0] frame_number;
        logic       last_frame;
    } out_t;

    typedef struct packed {
        logic [NUM_SMALL-1:0][6:0] small_number;
        logic [NUM_SMALL-1:0][2:0] small_mode;
        logic [6:0]                big_number;
        logic [2:0]                big_mode;
        logic [NUM_BAR-1:0][7:0]   bar_level;
        logic [NUM_BAR-1:0][2:0]   bar_mode;
        logic [NUM_BAR-1:0][2:0]   led_mode;
        logic                      slow_phase;
        logic                      fast_phase;
        logic [5:0]                chase_pattern;
    } disp_state_t;

    function automatic logic is_dark(input logic [2:0] mode, input logic slow,
                                     input logic fast);
        return (mode == MODE_OFF) || (mode == MODE_BLINK && !slow) ||
               (mode == MODE_FAST && !fast);
    endfunction

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] clamp_num(input logic [7:0] v);
        return (v > {1'b0, NUM_MAX}) ? {1'b0, NUM_MAX} : v;
    endfunction

    function automatic logic [7:0] bar_fill(input logic [2:0] mode, input logic [7:0] level,
                                            input logic slow, input logic fast);
        logic [7:0] f;
        if (is_dark(mode, slow, fast))
            f = 8'h00;
        else if (level < 8'd8)
            f = (8'd1 << level[2:0]) - 8'd1;
        else
            f = BAR_FULL;
        return f;
    endfunction

    function automatic logic [7:0] bar_cath(input logic bar, input logic [2:0] mode,
                                            input logic [7:0] level, input logic slow,
                                            input logic fast);
        logic [7:0] base;
        logic [7:0] c;
        base = bar ? 8'h08 : 8'h04;
        if (is_dark(mode, slow, fast))
            c = 8'h00;
        else if (level <= 8'd8)
            c = base;
        else if (level == 8'd9)
            c = base | 8'h01;
        else
            c = base | 8'h03;
        return c;
    endfunction

    function automatic logic led_lit(input logic [2:0] mode, input logic slow);
        return (mode == MODE_STEADY) || (mode == MODE_BLINK && slow);
    endfunction

endpackage

`default_nettype wire

[hdl/msc_glyph.sv]
// Digit glyph unit: turns a mode and a two-digit number into one segment pattern.
// Depends on msc_pkg.
`default_nettype none

module msc_glyph (
    input  wire logic [2:0] mode,
    input  wire logic [6:0] number,
    input  wire logic       tens,
    input  wire logic       slow_phase,
    input  wire logic       fast_phase,
    input  wire logic [5:0] chase_pattern,
    output logic      [7:0] glyph
);

    logic [6:0]  num;
    logic [13:0] prod;
    logic [3:0]  tens_digit;
    logic [6:0]  tens_times;
    logic [6:0]  units_full;
    logic [3:0]  digit;

    always_comb
    begin
        num        = (number > msc_pkg::NUM_MAX) ? msc_pkg::NUM_MAX : number;
        prod       = 14'(num) * 14'd103;
        tens_digit = prod[13:10];
        tens_times = 7'(tens_digit) * 7'd10;
        units_full = num - tens_times;
        digit      = tens ? tens_digit : units_full[3:0];

        if (msc_pkg::is_dark(mode, slow_phase, fast_phase))
            glyph = 8'h00;
        else if (mode == msc_pkg::MODE_ERROR)
            glyph = tens ? msc_pkg::GLYPH_E : msc_pkg::GLYPH_R;
        else if (mode == msc_pkg::MODE_EMPTY)
            glyph = msc_pkg::GLYPH_DASH;
        else if (mode == msc_pkg::MODE_LOAD)
            glyph = {2'b00, chase_pattern};
        else
            glyph = msc_pkg::digit_glyph(digit);
    end

endmodule

`default_nettype wire

[hdl/msc_state.sv]
// Display state store: numbers, modes, bar levels, blink counter and chase pattern.
// Depends on msc_pkg.
`default_nettype none

module msc_state #(
    parameter int BLINK_PERIOD = msc_pkg::BLINK_PERIOD_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire msc_pkg::in_t          cmd,
    output msc_pkg::disp_state_t       disp
);

    localparam int CNT_W      = $clog2(BLINK_PERIOD);
    localparam int HALF       = BLINK_PERIOD / 2;
    localparam int CHASE_STEP = BLINK_PERIOD / 5;
    localparam int SUB_W      = $clog2(CHASE_STEP);

    localparam msc_pkg::disp_state_t ST_RESET = '{
        small_number:  '0,
        small_mode:    '0,
        big_number:    '0,
        big_mode:      '0,
        bar_level:     '0,
        bar_mode:      '0,
        led_mode:      '0,
        slow_phase:    1'b1,
        fast_phase:    1'b1,
        chase_pattern: 6'h01
    };

    msc_pkg::disp_state_t st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUB_W-1:0] sub_reg, sub_next;

    logic [CNT_W:0] cnt_inc;
    logic [SUB_W:0] sub_inc;
    logic           wrap;
    logic [6:0]     chase_shift;
    logic [6:0]     num;

    assign disp = st_reg;

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        sub_next    = sub_reg;
        num         = 7'(msc_pkg::clamp_num(cmd.value));
        cnt_inc     = {1'b0, cnt_reg} + 1'b1;
        sub_inc     = {1'b0, sub_reg} + 1'b1;
        wrap        = (cnt_inc == (CNT_W+1)'(BLINK_PERIOD));
        chase_shift = {st_reg.chase_pattern, 1'b0};

        if (accept)
        begin
            case (cmd.action)
                msc_pkg::ACT_TICK:
                begin
                    if (wrap)
                    begin
                        cnt_next           = '0;
                        st_next.slow_phase = ~st_reg.slow_phase;
                        st_next.fast_phase = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[CNT_W-1:0];
                        if (cnt_inc == (CNT_W+1)'(HALF))
                            st_next.fast_phase = 1'b0;
                    end
                    if (wrap || sub_inc == (SUB_W+1)'(CHASE_STEP))
                        sub_next = '0;
                    else
                        sub_next = sub_inc[SUB_W-1:0];
                    if (sub_next == '0)
                    begin
                        if (chase_shift == 7'h40 || chase_shift == 7'h00)
                            st_next.chase_pattern = 6'h01;
                        else
                            st_next.chase_pattern = chase_shift[5:0];
                    end
                end
                msc_pkg::ACT_SET_SMALL:
                begin
                    if (cmd.index < 3'(msc_pkg::NUM_SMALL))
                    begin
                        st_next.small_number[cmd.index] = num;
                        st_next.small_mode[cmd.index]   = cmd.status;
                    end
                end
                msc_pkg::ACT_SET_BIG:
                begin
                    st_next.big_number = num;
                    st_next.big_mode   = cmd.status;
                end
                msc_pkg::ACT_SET_BAR:
                begin
                    if (cmd.index < 3'(msc_pkg::NUM_BAR))
                    begin
                        st_next.bar_level[cmd.index[0]] = cmd.value;
                        st_next.bar_mode[cmd.index[0]]  = cmd.status;
                    end
                end
                msc_pkg::ACT_SET_LED:
                begin
                    if (cmd.index < 3'(msc_pkg::NUM_BAR))
                        st_next.led_mode[cmd.index[0]] = cmd.status;
                end
                msc_pkg::ACT_SET_ALL:
                begin
                    for (int i = 0; i < msc_pkg::NUM_SMALL; i++)
                        st_next.small_mode[i] = cmd.status;
                    st_next.big_mode    = cmd.status;
                    st_next.bar_mode[1] = cmd.status;
                    st_next.led_mode[0] = cmd.status;
                    st_next.led_mode[1] = cmd.status;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_RESET;
            cnt_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            sub_reg <= sub_next;
        end
    end

endmodule

`default_nettype wire

[hdl/multiplexed_display_scanner_core.sv]
// Top level of the multiplexed display scanner: command port, frame sequencer, output register.
// Depends on msc_pkg, msc_state, msc_glyph and multiplexed_display_scanner_core_macros.svh.
//
//   channel   handshake         payload         when taken
//   command   start / busy      cmd (in_t)      rising edge with start high, busy low
//   result    strobe            result (out_t)  rising edge ending the strobe cycle
//
// A write transaction returns nothing and does not make the core busy.
// A tick transaction is accepted and advances the blink counter, then the core builds
// one scan frame per cycle through the two glyph units; busy is high for those 14 frames.
// Each frame is registered onto result in the cycle after it is built, with strobe high.
// rst_n resets all display state; the receiver cannot stall the result.
`default_nettype none
`include "multiplexed_display_scanner_core_macros.svh"

module multiplexed_display_scanner_core #(
    parameter int BLINK_PERIOD = msc_pkg::BLINK_PERIOD_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire msc_pkg::in_t  cmd,
    output logic               strobe,
    output msc_pkg::out_t      result
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t               state_reg;
    logic [3:0]           frame_reg;
    logic                 strobe_reg;
    msc_pkg::out_t        result_reg;

    logic                 accept;
    msc_pkg::disp_state_t disp;
    logic [2:0]           small_sel;
    logic [7:0]           small_glyph;
    logic [7:0]           big_glyph;
    logic                 bar_sel;
    logic [2:0]           high_idx;
    msc_pkg::out_t        frame_out;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_SCAN);
    assign strobe = strobe_reg;
    assign result = result_reg;

    msc_state #(
        .BLINK_PERIOD(BLINK_PERIOD)
    ) u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .cmd   (cmd),
        .disp  (disp)
    );

    assign small_sel = frame_reg[3:1];

    msc_glyph u_small_glyph (
        .mode         (disp.small_mode[small_sel]),
        .number       (disp.small_number[small_sel]),
        .tens         (frame_reg[0]),
        .slow_phase   (disp.slow_phase),
        .fast_phase   (disp.fast_phase),
        .chase_pattern(disp.chase_pattern),
        .glyph        (small_glyph)
    );

    msc_glyph u_big_glyph (
        .mode         (disp.big_mode),
        .number       (disp.big_number),
        .tens         (frame_reg[2]),
        .slow_phase   (disp.slow_phase),
        .fast_phase   (disp.fast_phase),
        .chase_pattern(disp.chase_pattern),
        .glyph        (big_glyph)
    );

    always_comb
    begin
        bar_sel  = (frame_reg >= 4'd11);
        high_idx = 3'(frame_reg - 4'd8);

        frame_out.led_bar_byte = 8'h00;
        if (msc_pkg::led_lit(disp.led_mode[1], disp.slow_phase))
            frame_out.led_bar_byte = frame_out.led_bar_byte | msc_pkg::LED1_BIT;
        if (msc_pkg::led_lit(disp.led_mode[0], disp.slow_phase))
            frame_out.led_bar_byte = frame_out.led_bar_byte | msc_pkg::LED0_BIT;

        if (frame_reg < 4'd8)
        begin
            frame_out.anode_byte       = big_glyph;
            frame_out.select_high_byte = frame_reg[2] ? msc_pkg::SEL_BIG_HI
                                                      : msc_pkg::SEL_BIG_LO;
            frame_out.select_low_byte  = ~(8'd1 << frame_reg[2:0]);
        end
        else
        begin
            frame_out.led_bar_byte = (frame_out.led_bar_byte & msc_pkg::CATH_KEEP) |
                msc_pkg::bar_cath(bar_sel, disp.bar_mode[bar_sel], disp.bar_level[bar_sel],
                                  disp.slow_phase, disp.fast_phase);
            frame_out.anode_byte       = msc_pkg::bar_fill(disp.bar_mode[bar_sel],
                disp.bar_level[bar_sel], disp.slow_phase, disp.fast_phase);
            frame_out.select_high_byte = msc_pkg::SEL_HIGH_BASE & ~(8'd1 << high_idx);
            frame_out.select_low_byte  = 8'hFF;
        end

        frame_out.segment_byte = ~small_glyph;
        frame_out.frame_number = frame_reg;
        frame_out.last_frame   = (frame_reg == msc_pkg::LAST_FRAME);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            frame_reg  <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    frame_reg <= '0;
                    if (accept && cmd.action == msc_pkg::ACT_TICK)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // emit the frame and advance
                    result_reg <= frame_out;
                    strobe_reg <= 1'b1;
                    if (frame_reg == msc_pkg::LAST_FRAME)
                    begin
                        frame_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        frame_reg <= frame_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MDSC_ASSERT_NEXT(a_tick_starts_scan, accept && cmd.action == msc_pkg::ACT_TICK, busy)
    `MDSC_ASSERT_NEXT(a_last_frame_ends_scan, busy && frame_reg == msc_pkg::LAST_FRAME, !busy && strobe && result.last_frame)
    `MDSC_ASSERT_NEXT(a_gap_after_last, strobe && result.last_frame, !strobe)
    `MDSC_ASSERT_NEXT(a_frames_in_order, strobe && !result.last_frame, strobe && result.frame_number == $past(result.frame_number) + 4'd1)
    `MDSC_ASSERT_SAME(a_no_write_while_busy, busy, !accept)

endmodule

`default_nettype wire
